// ===== src/rasc_pkg.sv =====
// ---------------------------------------------------------------------------
// rasc_pkg: shared types and codes for the rational add/sub/compare block
// Beat structs, operation codes of the datapath and the control/status bundles.
// ---------------------------------------------------------------------------
package rasc_pkg;

    // width of the exact internal magnitudes
    localparam int DW = 64;

    // operation modes
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_CMP = 2'd2;

    // datapath operations, in the order the sequencer walks them
    localparam int OPW = 5;
    localparam logic [OPW-1:0] OP_LOAD   = 5'd0;
    localparam logic [OPW-1:0] OP_GCD_A  = 5'd1;
    localparam logic [OPW-1:0] OP_DIV_AN = 5'd2;
    localparam logic [OPW-1:0] OP_DIV_AD = 5'd3;
    localparam logic [OPW-1:0] OP_GCD_B  = 5'd4;
    localparam logic [OPW-1:0] OP_DIV_BN = 5'd5;
    localparam logic [OPW-1:0] OP_DIV_BD = 5'd6;
    localparam logic [OPW-1:0] OP_CHECK  = 5'd7;
    localparam logic [OPW-1:0] OP_GCD_D  = 5'd8;
    localparam logic [OPW-1:0] OP_DIV_FA = 5'd9;
    localparam logic [OPW-1:0] OP_DIV_FB = 5'd10;
    localparam logic [OPW-1:0] OP_MUL_TA = 5'd11;
    localparam logic [OPW-1:0] OP_MUL_TB = 5'd12;
    localparam logic [OPW-1:0] OP_MUL_SD = 5'd13;
    localparam logic [OPW-1:0] OP_COMB   = 5'd14;
    localparam logic [OPW-1:0] OP_GCD_S  = 5'd15;
    localparam logic [OPW-1:0] OP_DIV_SN = 5'd16;
    localparam logic [OPW-1:0] OP_DIV_SD = 5'd17;
    localparam logic [OPW-1:0] OP_FIN    = 5'd18;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] a_numerator;
        logic signed [31:0] a_denominator;
        logic signed [31:0] b_numerator;
        logic signed [31:0] b_denominator;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_numerator;
        logic [30:0]        result_denominator;
        logic               is_equal;
        logic               zero_denominator;
        logic               overflow;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic           go;
        logic [OPW-1:0] op;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic zero;
        logic skip;
    } stat_t;

    function automatic logic is_gcd(input logic [OPW-1:0] op);
        return (op == OP_GCD_A) || (op == OP_GCD_B) || (op == OP_GCD_D) ||
               (op == OP_GCD_S);
    endfunction

    function automatic logic is_div(input logic [OPW-1:0] op);
        return (op == OP_DIV_AN) || (op == OP_DIV_AD) || (op == OP_DIV_BN) ||
               (op == OP_DIV_BD) || (op == OP_DIV_FA) || (op == OP_DIV_FB) ||
               (op == OP_DIV_SN) || (op == OP_DIV_SD);
    endfunction

endpackage

// ===== src/rasc_gcd.sv =====
// ---------------------------------------------------------------------------
// rasc_gcd: binary greatest common divisor
// One shift or subtract-and-shift per cycle; gcd(x, 0) is x.
// ---------------------------------------------------------------------------
module rasc_gcd (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [rasc_pkg::DW-1:0] x_in,
    input  logic [rasc_pkg::DW-1:0] y_in,
    output logic                    done,
    output logic [rasc_pkg::DW-1:0] g
);

    localparam int KW = $clog2(rasc_pkg::DW);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [rasc_pkg::DW-1:0] x_reg, x_next;
    logic [rasc_pkg::DW-1:0] y_reg, y_next;
    logic [rasc_pkg::DW-1:0] g_reg, g_next;
    logic [KW-1:0]           k_reg, k_next;

    // one reduction step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        g_next    = g_reg;
        k_next    = k_reg;
        if (start)
        begin
            x_next    = x_in;
            y_next    = y_in;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg == '0)
            begin
                g_next    = y_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (y_reg == '0)
            begin
                g_next    = x_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_next = (x_reg - y_reg) >> 1;
            end
            else
            begin
                y_next = (y_reg - x_reg) >> 1;
            end
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand flops
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        g_reg <= g_next;
        k_reg <= k_next;
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

// ===== src/rasc_div.sv =====
// ---------------------------------------------------------------------------
// rasc_div: restoring unsigned divider
// One quotient bit per cycle, quotient returned with a done pulse.
// ---------------------------------------------------------------------------
module rasc_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [rasc_pkg::DW-1:0] dividend,
    input  logic [rasc_pkg::DW-1:0] divisor,
    output logic                    done,
    output logic [rasc_pkg::DW-1:0] quotient
);

    localparam int W  = rasc_pkg::DW;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    rem_sh;
    logic [W+1:0]  diff;

    // shift in one dividend bit and try the subtraction
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W+1])
            begin
                rem_next = diff[W:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working flops
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/rasc_dp.sv =====
// ---------------------------------------------------------------------------
// rasc_dp: datapath of the rational unit
// Operand registers, shared gcd unit, shared divider and one 32x32 multiplier.
// ---------------------------------------------------------------------------
module rasc_dp #(
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rasc_pkg::cmd_t      cmd,
    input  rasc_pkg::in_item_t  operand,
    output rasc_pkg::stat_t     stat,
    output rasc_pkg::out_item_t result
);

    localparam int W = rasc_pkg::DW;
    localparam logic [W-1:0] MAX_POS = (W'(1) << (VALUE_BITS - 1)) - W'(1);

    logic [1:0]                mode_reg;
    logic                      a_neg_reg, b_neg_reg, s_neg_reg;
    logic [W-1:0]              a_num_reg, a_den_reg, b_num_reg, b_den_reg;
    logic [W-1:0]              s_num_reg, s_den_reg;
    logic [W-1:0]              fa_reg, fb_reg, ta_reg, tb_reg;
    logic                      zero_reg, ovf_reg, eq_reg, cmp_reg;
    logic [rasc_pkg::OPW-1:0]  op_reg;
    rasc_pkg::out_item_t       res_reg;
    rasc_pkg::out_item_t       res_fin;

    logic                      gcd_start, gcd_done, div_start, div_done;
    logic [W-1:0]              gcd_x, gcd_y, gcd_g, div_n, div_q;
    logic [31:0]               mul_x, mul_y;
    logic [W-1:0]              prod;
    logic                      sb;
    logic [W-1:0]              s_out_num;

    function automatic logic in_rng(input logic neg, input logic [W-1:0] num,
                                    input logic [W-1:0] den);
        return (den <= MAX_POS) && (neg ? (num <= MAX_POS + W'(1)) : (num <= MAX_POS));
    endfunction

    function automatic logic [W-1:0] mag32(input logic [31:0] v);
        return v[31] ? W'(33'h1_0000_0000 - {1'b0, v}) : W'(v);
    endfunction

    assign gcd_start = cmd.go && rasc_pkg::is_gcd(cmd.op);
    assign div_start = cmd.go && rasc_pkg::is_div(cmd.op);

    // gcd operand pair
    always_comb
    begin
        case (cmd.op)
            rasc_pkg::OP_GCD_A: begin gcd_x = a_num_reg; gcd_y = a_den_reg; end
            rasc_pkg::OP_GCD_B: begin gcd_x = b_num_reg; gcd_y = b_den_reg; end
            rasc_pkg::OP_GCD_D: begin gcd_x = a_den_reg; gcd_y = b_den_reg; end
            default:            begin gcd_x = s_num_reg; gcd_y = s_den_reg; end
        endcase
    end

    // dividend select, divisor is always the last gcd
    always_comb
    begin
        case (cmd.op)
            rasc_pkg::OP_DIV_AN: div_n = a_num_reg;
            rasc_pkg::OP_DIV_AD: div_n = a_den_reg;
            rasc_pkg::OP_DIV_BN: div_n = b_num_reg;
            rasc_pkg::OP_DIV_BD: div_n = b_den_reg;
            rasc_pkg::OP_DIV_FA: div_n = b_den_reg;
            rasc_pkg::OP_DIV_FB: div_n = a_den_reg;
            rasc_pkg::OP_DIV_SN: div_n = s_num_reg;
            default:             div_n = s_den_reg;
        endcase
    end

    // multiplier operands
    always_comb
    begin
        case (cmd.op)
            rasc_pkg::OP_MUL_TA: begin mul_x = a_num_reg[31:0]; mul_y = fa_reg[31:0]; end
            rasc_pkg::OP_MUL_TB: begin mul_x = b_num_reg[31:0]; mul_y = fb_reg[31:0]; end
            default:             begin mul_x = a_den_reg[31:0]; mul_y = fa_reg[31:0]; end
        endcase
    end

    assign prod      = {32'd0, mul_x} * {32'd0, mul_y};
    assign sb        = (mode_reg == rasc_pkg::MODE_SUB) ? !b_neg_reg : b_neg_reg;
    assign s_out_num = s_neg_reg ? (~s_num_reg + W'(1)) : s_num_reg;

    // final result beat, zero denominator first, then overflow
    always_comb
    begin
        res_fin = '0;
        res_fin.result_denominator = 31'd1;
        if (zero_reg)
            res_fin.zero_denominator = 1'b1;
        else if (ovf_reg)
            res_fin.overflow = 1'b1;
        else if (cmp_reg)
            res_fin.is_equal = eq_reg;
        else if (!in_rng(s_neg_reg, s_num_reg, s_den_reg))
            res_fin.overflow = 1'b1;
        else
        begin
            res_fin.result_numerator   = s_out_num[31:0];
            res_fin.result_denominator = s_den_reg[30:0];
        end
    end

    rasc_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x_in  (gcd_x),
        .y_in  (gcd_y),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rasc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_q)
    );

    // operation and write-back registers
    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            op_reg <= cmd.op;
            case (cmd.op)
                rasc_pkg::OP_LOAD:
                begin
                    mode_reg  <= operand.mode;
                    a_neg_reg <= operand.a_numerator[31] ^ operand.a_denominator[31];
                    b_neg_reg <= operand.b_numerator[31] ^ operand.b_denominator[31];
                    a_num_reg <= mag32(operand.a_numerator);
                    a_den_reg <= mag32(operand.a_denominator);
                    b_num_reg <= mag32(operand.b_numerator);
                    b_den_reg <= mag32(operand.b_denominator);
                    zero_reg  <= (operand.a_denominator == '0) ||
                                 (operand.b_denominator == '0);
                    ovf_reg   <= 1'b0;
                    eq_reg    <= 1'b0;
                    cmp_reg   <= 1'b0;
                end
                rasc_pkg::OP_CHECK:
                begin
                    ovf_reg <= !in_rng(a_neg_reg, a_num_reg, a_den_reg) ||
                               !in_rng(b_neg_reg, b_num_reg, b_den_reg);
                    cmp_reg <= (mode_reg >= rasc_pkg::MODE_CMP);
                    eq_reg  <= (a_neg_reg == b_neg_reg) && (a_num_reg == b_num_reg) &&
                               (a_den_reg == b_den_reg);
                end
                rasc_pkg::OP_MUL_TA: ta_reg    <= prod;
                rasc_pkg::OP_MUL_TB: tb_reg    <= prod;
                rasc_pkg::OP_MUL_SD: s_den_reg <= prod;
                rasc_pkg::OP_COMB:
                begin
                    if (a_neg_reg == sb)
                    begin
                        s_num_reg <= ta_reg + tb_reg;
                        s_neg_reg <= a_neg_reg;
                    end
                    else if (ta_reg >= tb_reg)
                    begin
                        s_num_reg <= ta_reg - tb_reg;
                        s_neg_reg <= a_neg_reg;
                    end
                    else
                    begin
                        s_num_reg <= tb_reg - ta_reg;
                        s_neg_reg <= sb;
                    end
                end
                rasc_pkg::OP_FIN: res_reg <= res_fin;
                default: ;
            endcase
        end
        // multi-cycle results, zero numerators normalised to 0/1
        if (gcd_done || div_done)
        begin
            case (op_reg)
                rasc_pkg::OP_DIV_AN: a_num_reg <= div_q;
                rasc_pkg::OP_DIV_AD:
                begin
                    a_den_reg <= (a_num_reg == '0) ? W'(1) : div_q;
                    if (a_num_reg == '0)
                        a_neg_reg <= 1'b0;
                end
                rasc_pkg::OP_DIV_BN: b_num_reg <= div_q;
                rasc_pkg::OP_DIV_BD:
                begin
                    b_den_reg <= (b_num_reg == '0) ? W'(1) : div_q;
                    if (b_num_reg == '0)
                        b_neg_reg <= 1'b0;
                end
                rasc_pkg::OP_DIV_FA: fa_reg <= div_q;
                rasc_pkg::OP_DIV_FB: fb_reg <= div_q;
                rasc_pkg::OP_DIV_SN: s_num_reg <= div_q;
                rasc_pkg::OP_DIV_SD:
                begin
                    s_den_reg <= (s_num_reg == '0) ? W'(1) : div_q;
                    if (s_num_reg == '0)
                        s_neg_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign stat.done = gcd_done || div_done;
    assign stat.zero = zero_reg;
    assign stat.skip = ovf_reg || cmp_reg;
    assign result    = res_reg;

endmodule

// ===== src/rasc_ctrl.sv =====
// ---------------------------------------------------------------------------
// rasc_ctrl: sequencer of the rational unit
// Walks the datapath operations, waits on the iterative units, holds the result.
// ---------------------------------------------------------------------------
module rasc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            operand_valid,
    output logic            operand_stall,
    output logic            result_valid,
    input  logic            result_stall,
    input  rasc_pkg::stat_t stat,
    output rasc_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [rasc_pkg::OPW-1:0] step_reg, step_next;
    logic [rasc_pkg::OPW-1:0] op_eff;

    // early exits jump straight to the result step
    always_comb
    begin
        if ((step_reg == rasc_pkg::OP_GCD_A && stat.zero) ||
            (step_reg == rasc_pkg::OP_GCD_D && stat.skip))
            op_eff = rasc_pkg::OP_FIN;
        else
            op_eff = step_reg;
    end

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.go     = 1'b0;
        cmd.op     = op_eff;
        case (state_reg)
            S_IDLE:
            begin
                cmd.op = rasc_pkg::OP_LOAD;
                if (operand_valid)
                begin
                    cmd.go     = 1'b1;
                    step_next  = rasc_pkg::OP_GCD_A;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.go    = 1'b1;
                step_next = op_eff;
                if (op_eff == rasc_pkg::OP_FIN)
                    state_next = S_DONE;
                else if (rasc_pkg::is_gcd(op_eff) || rasc_pkg::is_div(op_eff))
                    state_next = S_WAIT;
                else
                    step_next = op_eff + rasc_pkg::OPW'(1);
            end
            S_WAIT:
            begin
                if (stat.done)
                begin
                    step_next  = step_reg + rasc_pkg::OPW'(1);
                    state_next = S_ISSUE;
                end
            end
            S_DONE:
            begin
                if (!result_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= rasc_pkg::OP_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign operand_stall = (state_reg != S_IDLE);
    assign result_valid  = (state_reg == S_DONE);

endmodule

// ===== src/rational_add_sub_compare.sv =====
// ---------------------------------------------------------------------------
// rational_add_sub_compare: exact add, subtract or equality test of fractions
// Top level joining the sequencer and the datapath.
// ---------------------------------------------------------------------------
// Usage:
//   operand channel: one beat carries mode and both signed fractions; it is
//   taken when operand_valid is high and operand_stall low. The block works
//   on one beat at a time and stalls the operand channel until the result
//   beat has been taken.
//   result channel: result_valid rises with the reduced fraction and flags;
//   while result_stall is high the beat is held unchanged.
//   Sequence: with a zero denominator the sequencer goes from the operand
//   beat straight to the result step. Otherwise each operand reduction
//   costs one binary gcd and two divisions, after which compare or an
//   out-of-range operand goes to the result step; add/subtract adds a gcd
//   and two divisions for the common denominator and a gcd and two
//   divisions for the final reduction, all on the shared bit-serial
//   divider and gcd.
//   Reset: asynchronous, active low; the sequencer returns to idle with no
//   result pending. VALUE_BITS sets the signed range results must fit.
// ---------------------------------------------------------------------------
module rational_add_sub_compare #(
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                operand_valid,
    output logic                operand_stall,
    input  rasc_pkg::in_item_t  operand,
    output logic                result_valid,
    input  logic                result_stall,
    output rasc_pkg::out_item_t result
);

    rasc_pkg::cmd_t  cmd;
    rasc_pkg::stat_t stat;

    rasc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .stat          (stat),
        .cmd           (cmd)
    );

    rasc_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .operand (operand),
        .stat    (stat),
        .result  (result)
    );

endmodule

// ===== src/rasc_chk.sv =====
// ---------------------------------------------------------------------------
// rasc_chk: port checker for the rational unit
// Watches the two channels and the result flags over time.
// ---------------------------------------------------------------------------
module rasc_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                operand_valid,
    input logic                operand_stall,
    input logic                result_valid,
    input logic                result_stall,
    input rasc_pkg::out_item_t result
);

    // a held result beat stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat dropped or changed while stalled");

    // one item in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> operand_stall)
        else $error("operand taken while a result is pending");

    // no result in the cycle after an operand beat
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        operand_valid && !operand_stall |=> !result_valid)
        else $error("result appeared too early");

    // zero denominator gives 0/1 and no other flag
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_denominator |->
            result.result_numerator == '0 && result.result_denominator == 31'd1 &&
            !result.overflow && !result.is_equal)
        else $error("zero denominator result malformed");

endmodule

bind rational_add_sub_compare rasc_chk u_rasc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_valid (operand_valid),
    .operand_stall (operand_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
);
